>>> rtl/core/vga_pkg.sv
package vga_pkg;

    localparam int GRID_SIZE_DEF = 256;
    localparam int SUM_W         = 48;
    localparam int SAMPLE_W      = 32;
    localparam int PROD_W        = 64;
    localparam int ACC_W         = 96;
    localparam int QUOT_W        = 40;
    localparam int FRAC_W        = 56;

    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_ACC  = 2'd0,
        ST_DROP = 2'd1,
        ST_READ = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MAG,
        S_LO,
        S_HI,
        S_SUM,
        S_IDX,
        S_RD,
        S_UPD
    } t_state;

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0]    acc,
        input logic [SAMPLE_W-1:0] smp
    );
        logic [SUM_W:0] sum;
        sum = {acc[SUM_W-1], acc} + {{(SUM_W-SAMPLE_W+1){smp[SAMPLE_W-1]}}, smp};
        if (sum[SUM_W] != sum[SUM_W-1]) begin
            sat_add = sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_add = sum[SUM_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/visibility_grid_accumulator.sv
// Nearest-neighbour gridder: an accumulate item maps (u, v) and frequency to a cell with
// index round(coord * frequency * index_scale / 2^56) + GRID_SIZE/2 and adds the complex
// sample into 48-bit saturating sums; a read item returns one cell. Items are handled one
// at a time: an accumulate item steps through S_MAG, S_LO, S_HI, S_SUM and S_IDX for each
// coordinate around the one shared 32x32 multiplier, then S_RD and S_UPD for the read and
// write-back of the grid memory; a read item steps through S_RD and S_UPD. A result still
// waiting for i_ready holds the item in S_UPD until the output register is free. After
// reset the grid memory is cleared one entry a cycle, all 2^(2*ceil(log2(GRID_SIZE)))
// entries (65536 at the default size), during which o_ready stays low. index_scale is
// used as soon as it is written, so write it only while no item is in flight.
module visibility_grid_accumulator #(
    parameter int GRID_SIZE = vga_pkg::GRID_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_u_coord,
    input  logic [31:0] i_v_coord,
    input  logic [31:0] i_frequency,
    input  logic [31:0] i_sample_re,
    input  logic [31:0] i_sample_im,
    input  logic [7:0]  i_read_row,
    input  logic [7:0]  i_read_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_cell_row,
    output logic [7:0]  o_cell_col,
    output logic [47:0] o_sum_real,
    output logic [47:0] o_sum_imag
);

    import vga_pkg::*;

    localparam int IDX_W = $clog2(GRID_SIZE);
    localparam int AW    = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;
    localparam int MEM_W = 2 * SUM_W;
    localparam logic [QUOT_W-1:0] HALF  = QUOT_W'(GRID_SIZE / 2);
    localparam logic [QUOT_W-1:0] UPPER = QUOT_W'(GRID_SIZE - GRID_SIZE / 2);
    localparam logic [ACC_W-1:0]  ROUND = ACC_W'(1) << (FRAC_W - 1);

    t_state r_state, n_state;

    logic                 r_axis;
    logic                 r_kind;
    logic [31:0]          r_u_coord, r_v_coord, r_freq, r_sample_re, r_sample_im;
    logic [7:0]           r_read_row, r_read_col;
    logic [31:0]          r_index_scale;
    logic [PROD_W-1:0]    r_prod, r_a;
    logic [ACC_W-1:0]     r_acc;
    logic [IDX_W-1:0]     r_idx_u, r_idx_v;
    logic                 r_ok_u, r_ok;
    logic [AW-1:0]        r_addr, r_clr;

    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [7:0]           r_out_row, r_out_col;
    logic [SUM_W-1:0]     r_out_real, r_out_imag;

    logic [31:0]          cur_coord, mag, mul_x, mul_y;
    logic                 cur_neg, idx_ok, can_out, rd_ok, mem_we;
    logic [QUOT_W-1:0]    quot, idx_dn, idx_up;
    logic [IDX_W-1:0]     idx_now;
    logic [IDX_W+7:0]     rd_row_ext, rd_col_ext, row_ext, col_ext;
    logic [AW-1:0]        waddr;
    logic [MEM_W-1:0]     wdata, rdata;
    logic [SUM_W-1:0]     new_real, new_imag;

    assign cur_coord = r_axis ? r_v_coord : r_u_coord;
    assign cur_neg   = cur_coord[31];
    assign mag       = cur_neg ? (~cur_coord + 32'd1) : cur_coord;

    assign quot    = r_acc[ACC_W-1:FRAC_W];
    assign idx_dn  = HALF - quot;
    assign idx_up  = HALF + quot;
    assign idx_ok  = cur_neg ? (quot <= HALF) : (quot < UPPER);
    assign idx_now = cur_neg ? idx_dn[IDX_W-1:0] : idx_up[IDX_W-1:0];

    assign rd_row_ext = {{IDX_W{1'b0}}, i_read_row};
    assign rd_col_ext = {{IDX_W{1'b0}}, i_read_col};
    assign rd_ok = (32'(i_read_row) < 32'(GRID_SIZE)) && (32'(i_read_col) < 32'(GRID_SIZE));

    assign row_ext = {8'd0, r_idx_u};
    assign col_ext = {8'd0, r_idx_v};

    assign can_out  = !r_out_valid || i_ready;
    assign new_real = sat_add(rdata[MEM_W-1:SUM_W], r_sample_re);
    assign new_imag = sat_add(rdata[SUM_W-1:0], r_sample_im);

    always_comb begin
        mul_x = r_prod[31:0];
        mul_y = r_index_scale;
        case (r_state)
            S_MAG: begin
                mul_x = mag;
                mul_y = r_freq;
            end
            S_HI: begin
                mul_x = r_a[PROD_W-1:32];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == {AW{1'b1}}) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_kind == KIND_READ) ? S_RD : S_MAG;
                end
            end
            S_MAG:  n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_SUM;
            S_SUM:  n_state = S_IDX;
            S_IDX:  n_state = r_axis ? S_RD : S_MAG;
            S_RD:   n_state = S_UPD;
            S_UPD:  if (can_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = r_addr;
        wdata  = {new_real, new_imag};
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            waddr  = r_clr;
            wdata  = '0;
        end else if (r_state == S_UPD && can_out && r_kind == KIND_ACC && r_ok) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_index_scale <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_wr_en) begin
                r_index_scale <= i_cfg_wr_data;
            end
            if (r_state == S_UPD && can_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_x) * PROD_W'(mul_y);
        case (r_state)
            S_IDLE: begin
                r_axis      <= 1'b0;
                r_kind      <= i_kind;
                r_u_coord   <= i_u_coord;
                r_v_coord   <= i_v_coord;
                r_freq      <= i_frequency;
                r_sample_re <= i_sample_re;
                r_sample_im <= i_sample_im;
                r_read_row  <= i_read_row;
                r_read_col  <= i_read_col;
                r_ok        <= rd_ok;
                r_addr      <= {rd_row_ext[IDX_W-1:0], rd_col_ext[IDX_W-1:0]};
            end
            S_LO:  r_a   <= r_prod;
            S_HI:  r_acc <= {{(ACC_W-PROD_W){1'b0}}, r_prod} + ROUND;
            S_SUM: r_acc <= r_acc + {r_prod, 32'd0};
            S_IDX: begin
                if (!r_axis) begin
                    r_idx_u <= idx_now;
                    r_ok_u  <= idx_ok;
                    r_axis  <= 1'b1;
                end else begin
                    r_idx_v <= idx_now;
                    r_ok    <= r_ok_u && idx_ok;
                    r_addr  <= {r_idx_u, idx_now};
                end
            end
            S_UPD: begin
                if (can_out) begin
                    if (r_kind == KIND_READ) begin
                        r_out_status <= ST_READ;
                        r_out_row    <= r_read_row;
                        r_out_col    <= r_read_col;
                        r_out_real   <= r_ok ? rdata[MEM_W-1:SUM_W] : '0;
                        r_out_imag   <= r_ok ? rdata[SUM_W-1:0] : '0;
                    end else if (r_ok) begin
                        r_out_status <= ST_ACC;
                        r_out_row    <= row_ext[7:0];
                        r_out_col    <= col_ext[7:0];
                        r_out_real   <= new_real;
                        r_out_imag   <= new_imag;
                    end else begin
                        r_out_status <= ST_DROP;
                        r_out_row    <= '0;
                        r_out_col    <= '0;
                        r_out_real   <= '0;
                        r_out_imag   <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    vga_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_cell_row = r_out_row;
    assign o_cell_col = r_out_col;
    assign o_sum_real = r_out_real;
    assign o_sum_imag = r_out_imag;

endmodule

>>> rtl/core/vga_ram.sv
module vga_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/vga_checker.sv
module vga_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [7:0]  o_cell_row,
    input logic [7:0]  o_cell_col,
    input logic [47:0] o_sum_real,
    input logic [47:0] o_sum_imag
);

    import vga_pkg::*;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_ACC || o_status == ST_DROP || o_status == ST_READ))
        else $error("result status code unknown");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DROP) |->
            (o_cell_row == 8'd0 && o_cell_col == 8'd0 && o_sum_real == 48'd0
             && o_sum_imag == 48'd0))
        else $error("dropped item carries non-zero fields");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while previous item in flight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready))
        else $error("handshake active straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_cell_row)
                                   && $stable(o_cell_col) && $stable(o_sum_real)
                                   && $stable(o_sum_imag)))
        else $error("result changed while stalled");

endmodule

bind visibility_grid_accumulator vga_checker u_vga_checker (.*);

>>> bench/visibility_grid_accumulator_tb.sv
module visibility_grid_accumulator_tb;

    import vga_pkg::*;

    localparam int GRID   = GRID_SIZE_DEF;
    localparam int CENTRE = GRID / 2;
    localparam logic signed [48:0] SUM_HI = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] SUM_LO = -49'sh0_8000_0000_0000;

    typedef struct {
        logic        kind;
        logic [31:0] u_coord;
        logic [31:0] v_coord;
        logic [31:0] frequency;
        logic [31:0] sample_re;
        logic [31:0] sample_im;
        logic [7:0]  read_row;
        logic [7:0]  read_col;
    } t_vis_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  cell_row;
        logic [7:0]  cell_col;
        logic [47:0] sum_real;
        logic [47:0] sum_imag;
    } t_cell_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = KIND_ACC;
    logic [31:0] i_u_coord = '0;
    logic [31:0] i_v_coord = '0;
    logic [31:0] i_frequency = '0;
    logic [31:0] i_sample_re = '0;
    logic [31:0] i_sample_im = '0;
    logic [7:0]  i_read_row = '0;
    logic [7:0]  i_read_col = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_cell_row;
    logic [7:0]  o_cell_col;
    logic [47:0] o_sum_real;
    logic [47:0] o_sum_imag;

    logic [31:0]  index_scale_q = '0;
    bit [47:0]    grid_re [GRID*GRID];
    bit [47:0]    grid_im [GRID*GRID];
    logic [15:0]  hit_cells [$];
    t_cell_result pending_cells [$];
    t_cell_result want_cell;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           mismatches = 0;

    visibility_grid_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_u_coord     (i_u_coord),
        .i_v_coord     (i_v_coord),
        .i_frequency   (i_frequency),
        .i_sample_re   (i_sample_re),
        .i_sample_im   (i_sample_im),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_cell_row    (o_cell_row),
        .o_cell_col    (o_cell_col),
        .o_sum_real    (o_sum_real),
        .o_sum_imag    (o_sum_imag)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic longint grid_index(input logic [31:0] coord, input logic [31:0] freq);
        logic [31:0] mag;
        logic [95:0] prod;
        longint      idx;
        mag = coord[31] ? -coord : coord;
        prod = 96'(mag) * 96'(freq) * 96'(index_scale_q) + (96'd1 << 55);
        idx = longint'(prod[95:56]);
        return (coord[31] ? -idx : idx) + CENTRE;
    endfunction

    function automatic bit [47:0] saturate_sum(input bit [47:0] acc, input logic [31:0] smp);
        logic signed [48:0] total;
        total = $signed({acc[47], acc}) + $signed({{17{smp[31]}}, smp});
        if (total > SUM_HI) return SUM_HI[47:0];
        if (total < SUM_LO) return SUM_LO[47:0];
        return total[47:0];
    endfunction

    function automatic t_cell_result grid_update(input t_vis_item it);
        t_cell_result r;
        longint       iu;
        longint       iv;
        int           slot;
        r = '0;
        if (it.kind == KIND_READ) begin
            r.status   = ST_READ;
            r.cell_row = it.read_row;
            r.cell_col = it.read_col;
            slot = int'({it.read_row, it.read_col});
            r.sum_real = grid_re[slot];
            r.sum_imag = grid_im[slot];
        end else begin
            iu = grid_index(it.u_coord, it.frequency);
            iv = grid_index(it.v_coord, it.frequency);
            if (iu < 0 || iu >= GRID || iv < 0 || iv >= GRID) begin
                r.status = ST_DROP;
            end else begin
                slot = int'(iu) * GRID + int'(iv);
                grid_re[slot] = saturate_sum(grid_re[slot], it.sample_re);
                grid_im[slot] = saturate_sum(grid_im[slot], it.sample_im);
                r.status   = ST_ACC;
                r.cell_row = iu[7:0];
                r.cell_col = iv[7:0];
                r.sum_real = grid_re[slot];
                r.sum_imag = grid_im[slot];
                hit_cells.push_back(slot[15:0]);
                if (hit_cells.size() > 64) void'(hit_cells.pop_front());
            end
        end
        return r;
    endfunction

    function automatic t_vis_item make_acc(input logic [31:0] u, input logic [31:0] v,
                                           input logic [31:0] freq, input logic [31:0] re,
                                           input logic [31:0] im);
        t_vis_item it;
        it.kind      = KIND_ACC;
        it.u_coord   = u;
        it.v_coord   = v;
        it.frequency = freq;
        it.sample_re = re;
        it.sample_im = im;
        it.read_row  = $urandom;
        it.read_col  = $urandom;
        return it;
    endfunction

    function automatic t_vis_item make_read(input logic [7:0] row, input logic [7:0] col);
        t_vis_item it;
        it = make_acc($urandom, $urandom, $urandom, $urandom, $urandom);
        it.kind     = KIND_READ;
        it.read_row = row;
        it.read_col = col;
        return it;
    endfunction

    function automatic logic [31:0] aimed_coord(input logic [31:0] freq);
        logic [63:0] den;
        logic [95:0] reach;
        logic [63:0] span;
        logic [31:0] mag;
        den = 64'(freq) * 64'(index_scale_q);
        if (den == 0) return $urandom;
        reach = (96'd255 << 55) / 96'(den);
        span = (reach > 96'h8000_0000) ? 64'h8000_0000 : reach[63:0];
        if ($urandom_range(7) == 0) span = span + span / 16 + 1;
        if (span > 64'h8000_0000) span = 64'h8000_0000;
        mag = 32'({$urandom, $urandom} % (span + 1));
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [31:0] sample_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vis_item random_item();
        logic [31:0] freq;
        logic [15:0] slot;
        int          pick;
        pick = $urandom_range(99);
        freq = $urandom >> $urandom_range(31);
        if (pick < 60) begin
            return make_acc(aimed_coord(freq), aimed_coord(freq), freq,
                            sample_value(), sample_value());
        end
        if (pick < 75) return make_acc($urandom, $urandom, $urandom, $urandom, $urandom);
        if (hit_cells.size() != 0 && $urandom_range(1)) begin
            slot = hit_cells[$urandom_range(hit_cells.size() - 1)];
        end else begin
            slot = $urandom;
        end
        return make_read(slot[15:8], slot[7:0]);
    endfunction

    task automatic send_item(input t_vis_item it);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid     <= 1'b1;
        i_kind      <= it.kind;
        i_u_coord   <= it.u_coord;
        i_v_coord   <= it.v_coord;
        i_frequency <= it.frequency;
        i_sample_re <= it.sample_re;
        i_sample_im <= it.sample_im;
        i_read_row  <= it.read_row;
        i_read_col  <= it.read_col;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_cells.push_back(grid_update(it));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cells.size() != 0);
    endtask

    task automatic set_scale(input logic [31:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        index_scale_q = value;
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_ready && o_valid !== 1'b0) begin
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected item, status %0d row %0d col %0d", $time,
                         o_status, o_cell_row, o_cell_col);
                mismatches++;
            end else begin
                want_cell = pending_cells.pop_front();
                check_field("status", want_cell.status, o_status);
                check_field("cell_row", want_cell.cell_row, o_cell_row);
                check_field("cell_col", want_cell.cell_col, o_cell_col);
                check_field("sum_real", want_cell.sum_real, o_sum_real);
                check_field("sum_imag", want_cell.sum_imag, o_sum_imag);
            end
        end
    end

    task automatic test_directed_cells();
        idle_pct  = 0;
        stall_pct = 0;
        set_scale(32'h8000_0000);
        send_item(make_read(8'd0, 8'd0));
        send_item(make_read(8'd255, 8'd255));
        send_item(make_acc(32'h0040_0000, 32'hFFC0_0000, 32'd4, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_acc(32'h003F_FFFF, 32'hFFC0_0001, 32'd4, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_acc(32'hC000_0000, 32'h3FBF_FFFF, 32'd4, 32'd1, 32'hFFFF_FFFF));
        send_item(make_acc(32'h3FC0_0000, 32'd0, 32'd4, 32'd5, 32'd5));
        send_item(make_acc(32'd0, 32'hBFC0_0000, 32'd4, 32'd5, 32'd5));
        send_item(make_acc(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd9, 32'd9));
        send_item(make_acc(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd12345, -32'sd6789));
        send_item(make_acc(32'h00C0_0000, 32'hFF40_0000, 32'd4, 32'd100, 32'd200));
        send_item(make_acc(32'h0040_0000, 32'hFFC0_0000, 32'd4, -32'sd5, 32'd7));
        send_item(make_read(8'd129, 8'd127));
        send_item(make_read(8'd0, 8'd255));
        send_item(make_read(8'd128, 8'd128));
        send_item(make_read(8'd130, 8'd126));
        send_item(make_read(8'd255, 8'd0));
        drain_results();
        set_scale(32'hFFFF_FFFF);
        send_item(make_acc(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1));
        send_item(make_acc(32'd1, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'd3, 32'd4));
        send_item(make_read(8'd129, 8'd127));
        drain_results();
    endtask

    task automatic test_centre_pileup();
        idle_pct  = 0;
        stall_pct = 0;
        set_scale(32'd0);
        repeat (40) begin
            send_item(make_acc($urandom, $urandom, $urandom, 32'h7FFF_FFFF, 32'h8000_0000));
        end
        send_item(make_acc($urandom, $urandom, $urandom, 32'hFFFF_FFFF, 32'd1));
        send_item(make_read(8'(CENTRE), 8'(CENTRE)));
        drain_results();
    endtask

    task automatic test_random_gridding();
        int          idle_mix [6]  = '{0, 84, 0, 17, 84, 0};
        int          stall_mix [6] = '{0, 0, 84, 17, 0, 84};
        logic [31:0] scale_mix [6];
        scale_mix = '{32'hFFFF_FFFF, $urandom, 32'd1, 32'h8000_0000, $urandom,
                      $urandom >> $urandom_range(31)};
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            set_scale(scale_mix[ph]);
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            for (int n = 0; n < 192; n++) begin
                if (ph == 1 && n == 96) drain_results();
                send_item(random_item());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cells();
        test_centre_pileup();
        test_random_gridding();
        drain_results();
        stall_pct = 0;
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
